[design/kbdec_pkg.sv]
`default_nettype none

package kbdec_pkg;

    // character queue geometry
    localparam int unsigned FIFO_DEPTH = 256;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // key state table geometry
    localparam int unsigned KEY_COUNT = 128;
    localparam int unsigned KEY_IDX_W = $clog2(KEY_COUNT);

    // fixed field widths
    localparam int unsigned LEVEL_W = 9;

    // operation codes carried in s_axis_tuser
    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2,
        OP_LEDS  = 2'd3
    } t_opcode;

    // per-key state codes
    localparam logic [1:0] KS_UNTOUCHED = 2'b00;
    localparam logic [1:0] KS_PRESSED   = 2'b01;
    localparam logic [1:0] KS_RELEASED  = 2'b11;

    // register index of the enable bit (paddr[2])
    localparam logic REG_ENABLED = 1'b0;

    // scan codes with special handling
    localparam logic [7:0] SC_PREFIX   = 8'hE0;
    localparam logic [7:0] SC_UP       = 8'h48;
    localparam logic [7:0] SC_DOWN     = 8'h50;
    localparam logic [7:0] SC_LEFT     = 8'h4B;
    localparam logic [7:0] SC_RIGHT    = 8'h4D;
    localparam logic [6:0] SC_LSHIFT   = 7'h2A;
    localparam logic [6:0] SC_RSHIFT   = 7'h36;
    localparam logic [6:0] SC_LCTRL    = 7'h1D;
    localparam logic [6:0] SC_LALT     = 7'h38;
    localparam logic [6:0] SC_CAPS     = 7'h3A;
    localparam logic [6:0] SC_NUM      = 7'h45;
    localparam logic [6:0] SC_SCROLL   = 7'h46;

    // characters pushed for arrow keys
    localparam logic [7:0] CH_UP    = 8'h1E;
    localparam logic [7:0] CH_DOWN  = 8'h1F;
    localparam logic [7:0] CH_LEFT  = 8'h1C;
    localparam logic [7:0] CH_RIGHT = 8'h1D;

    // queue request and status
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } t_fifo_req;

    typedef struct packed {
        logic                  empty;
        logic [FIFO_CNT_W-1:0] level_next;
    } t_fifo_stat;

    // key table request
    typedef struct packed {
        logic                 wr;
        logic                 rd;
        logic [KEY_IDX_W-1:0] idx;
        logic [1:0]           wr_state;
    } t_key_req;

endpackage

`default_nettype wire

[design/kbdec_fifo.sv]
`default_nettype none

module kbdec_fifo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  kbdec_pkg::t_fifo_req   i_req,
    output kbdec_pkg::t_fifo_stat  o_stat,
    output logic [7:0]             o_rd_data
);
    import kbdec_pkg::*;

    logic [7:0]            r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_head, n_head;
    logic [FIFO_PTR_W-1:0] r_tail, n_tail;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic [7:0]            r_rd_data;
    logic                  full;
    logic                  do_push;

    // full queue drops the word
    assign full    = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign do_push = i_req.push && !full;

    // pointer and count update
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail  = (r_tail == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = n_count + 1'b1;
        end
        if (i_req.pop) begin
            n_head  = (r_head == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // storage, registered read port
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_req.wdata;
        end
        if (i_req.pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.level_next = n_count;
    assign o_rd_data         = r_rd_data;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.push && i_req.pop))
        else $error("push and pop in one cycle");

endmodule

`default_nettype wire

[design/kbdec_keys.sv]
`default_nettype none

module kbdec_keys (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  kbdec_pkg::t_key_req  i_req,
    output logic [1:0]           o_rd_state
);
    import kbdec_pkg::*;

    logic [1:0]           r_mem [KEY_COUNT];
    logic [KEY_COUNT-1:0] r_valid;
    logic [1:0]           r_rd_data;
    logic                 r_rd_valid;

    // per-entry valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr) begin
                r_valid[i_req.idx] <= 1'b1;
            end
            if (i_req.rd) begin
                r_rd_valid <= r_valid[i_req.idx];
            end
        end
    end

    // state storage, registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.idx] <= i_req.wr_state;
        end
        if (i_req.rd) begin
            r_rd_data <= r_mem[i_req.idx];
        end
    end

    // entry never written reads as untouched
    assign o_rd_state = r_rd_valid ? r_rd_data : KS_UNTOUCHED;

endmodule

`default_nettype wire

[design/scancode_to_ascii_decoder_core.sv]
// Input words pass the stage 1 and output registers to m_axis. Throughput: one
// word per cycle unless m_axis_tready stalls; queue and key table memories read
// in the cycle after acceptance and a result register decouples the output side.
// Reset (i_rst_n, synchronous, active low): queue empty, key table reads as
// untouched through valid flip-flops cleared at once, flags and enable cleared.
`default_nettype none

module scancode_to_ascii_decoder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data
    input  wire  [1:0]  s_axis_tuser,   // [1:0] opcode
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [6:0] event_code, [14:7] event_char, [22:15] read_char, [24:23] key_state,
    // [27:25] leds, [31:28] modifiers, [40:32] buffer_level, [47:41] zero
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [0] press_event, [1] release_event
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kbdec_pkg::*;

    localparam logic [7:0] MAP_PLAIN [64] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] MAP_SHIFT [64] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // control state
    logic        r_enabled;
    logic        r_ext, n_ext;
    logic [2:0]  r_locks, n_locks;
    logic [3:0]  r_mods, n_mods;

    // stage 1 (memory read in flight)
    logic               r_s1_valid;
    logic               r_s1_press, r_s1_release;
    logic [6:0]         r_s1_code;
    logic [7:0]         r_s1_char;
    logic               r_s1_pop;
    logic               r_s1_kuse;
    logic [1:0]         r_s1_kfix;
    logic [2:0]         r_s1_leds;
    logic [3:0]         r_s1_mods;
    logic [LEVEL_W-1:0] r_s1_level;

    // output register
    logic        r_o_valid;
    logic [47:0] r_o_data;
    logic [1:0]  r_o_user;

    t_opcode     op;
    logic [7:0]  din;
    logic [6:0]  code;
    logic        make;
    logic        accept, s1_adv;
    logic        is_scan, is_prefix, is_ext, is_norm;
    logic        arrow_hit;
    logic [7:0]  arrow_char;
    logic [7:0]  map_ch, ev_char;
    logic        cfg_wr;
    logic [7:0]  rd_char;
    logic [1:0]  kstate;
    logic [1:0]  key_rd;
    logic [7:0]  fifo_rd;
    t_fifo_req   fifo_req;
    t_fifo_stat  fifo_stat;
    t_key_req    key_req;

    // handshake
    assign s1_adv        = r_s1_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // input decode
    assign op        = t_opcode'(s_axis_tuser);
    assign din       = s_axis_tdata;
    assign code      = din[6:0];
    assign make      = !din[7];
    assign is_scan   = (op == OP_SCAN) && r_enabled;
    assign is_prefix = is_scan && (din == SC_PREFIX);
    assign is_ext    = is_scan && !is_prefix && r_ext;
    assign is_norm   = is_scan && !is_prefix && !r_ext;

    // arrow makes after the prefix
    always_comb begin
        arrow_hit  = 1'b1;
        arrow_char = CH_UP;
        unique case (din)
            SC_UP:    arrow_char = CH_UP;
            SC_DOWN:  arrow_char = CH_DOWN;
            SC_LEFT:  arrow_char = CH_LEFT;
            SC_RIGHT: arrow_char = CH_RIGHT;
            default:  arrow_hit  = 1'b0;
        endcase
    end

    // next prefix, modifier and lock flags
    always_comb begin
        n_ext   = r_ext;
        n_mods  = r_mods;
        n_locks = r_locks;
        if (is_prefix) begin
            n_ext = 1'b1;
        end else if (is_scan) begin
            n_ext = 1'b0;
        end
        if (is_norm) begin
            unique case (code)
                SC_LSHIFT: n_mods[0] = make;
                SC_RSHIFT: n_mods[1] = make;
                SC_LCTRL:  n_mods[2] = make;
                SC_LALT:   n_mods[3] = make;
                SC_CAPS:   n_locks[2] = r_locks[2] ^ make;
                SC_NUM:    n_locks[1] = r_locks[1] ^ make;
                SC_SCROLL: n_locks[0] = r_locks[0] ^ make;
                default:   ;
            endcase
        end
        if (op == OP_LEDS) begin
            n_locks = din[2:0];
        end
    end

    // character map with caps inversion of letters
    always_comb begin
        map_ch = (n_mods[1:0] != 2'b00) ? MAP_SHIFT[code[5:0]] : MAP_PLAIN[code[5:0]];
        if (code[6]) begin
            map_ch = 8'h00;
        end
        ev_char = map_ch;
        if (n_locks[2] && (((map_ch >= 8'h61) && (map_ch <= 8'h7A)) ||
                           ((map_ch >= 8'h41) && (map_ch <= 8'h5A)))) begin
            ev_char = map_ch ^ 8'h20;
        end
    end

    // queue and key table requests
    always_comb begin
        fifo_req.push  = accept && (is_norm || (is_ext && arrow_hit));
        fifo_req.pop   = accept && (op == OP_POP) && r_enabled && !fifo_stat.empty;
        fifo_req.wdata = is_norm ? ev_char : arrow_char;
        key_req.wr       = accept && is_norm;
        key_req.rd       = accept && (op == OP_QUERY);
        key_req.idx      = code;
        key_req.wr_state = make ? KS_PRESSED : KS_RELEASED;
    end

    kbdec_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (fifo_req),
        .o_stat    (fifo_stat),
        .o_rd_data (fifo_rd)
    );

    kbdec_keys u_keys (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (key_req),
        .o_rd_state (key_rd)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENABLED);
    assign prdata = (paddr[2] == REG_ENABLED) ? {31'b0, r_enabled} : 32'b0;

    // control state and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_ext      <= 1'b0;
            r_locks    <= '0;
            r_mods     <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_enabled <= pwdata[0];
            end
            if (accept) begin
                r_ext   <= n_ext;
                r_locks <= n_locks;
                r_mods  <= n_mods;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_press   <= is_norm && make;
            r_s1_release <= is_norm && !make;
            r_s1_code    <= is_norm ? code : 7'h00;
            r_s1_char    <= is_norm ? ev_char : 8'h00;
            r_s1_pop     <= fifo_req.pop;
            r_s1_kuse    <= (op == OP_QUERY) && r_enabled && !din[7];
            r_s1_kfix    <= ((op == OP_QUERY) && !r_enabled) ? KS_RELEASED : KS_UNTOUCHED;
            r_s1_leds    <= n_locks;
            r_s1_mods    <= n_mods;
            r_s1_level   <= LEVEL_W'(fifo_stat.level_next);
        end
    end

    // memory read data joins the word
    assign rd_char = r_s1_pop ? fifo_rd : 8'h00;
    assign kstate  = r_s1_kuse ? key_rd : r_s1_kfix;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_data <= {7'b0, r_s1_level, r_s1_mods, r_s1_leds, kstate,
                         rd_char, r_s1_char, r_s1_code};
            r_o_user <= {r_s1_release, r_s1_press};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

    // checks
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(r_s1_press && r_s1_release))
        else $error("press and release in one word");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("stage 1 word lost under stall");

    a_pop_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_pop) |-> !(r_s1_press || r_s1_release || r_s1_kuse))
        else $error("pop word carries other results");

endmodule

`default_nettype wire
